// ===== hw/rtl/fmet_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmet_pkg
// Shared types, codes and tables of the FM chip envelope tracker.
// ----------------------------------------------------------------------------
package fmet_pkg;

    localparam int NUM_OPS = 36;
    localparam int NUM_CH  = 18;
    localparam int OP_W    = 6;
    localparam int CH_W    = 5;
    localparam int LEVEL_W = 23;
    localparam int COUNT_W = 16;
    localparam int STEP_W  = 32;

    localparam int SAMPLE_RATE_DEFAULT = 44100;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 23'h400000;
    localparam longint unsigned    STEP_NUM   = 64'd4194304000;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ATTACK  = 3'd1;
    localparam logic [2:0] PH_DECAY   = 3'd2;
    localparam logic [2:0] PH_SUSTAIN = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_FM      = 3'd1;
    localparam logic [2:0] MODE_AM      = 3'd2;
    localparam logic [2:0] MODE_4OP_LOW = 3'd3;
    localparam logic [2:0] MODE_PERC    = 3'd7;

    localparam logic [7:0] REG_4OP_EN  = 8'h04;
    localparam logic [7:0] REG_NEW     = 8'h05;
    localparam logic [7:0] REG_KEY_LO  = 8'hb0;
    localparam logic [7:0] REG_KEY_2OP = 8'hb2;
    localparam logic [7:0] REG_KEY_4OP = 8'hb5;
    localparam logic [7:0] REG_KEY_PRC = 8'hb6;
    localparam logic [7:0] REG_KEY_HI  = 8'hb8;
    localparam logic [7:0] REG_RHYTHM  = 8'hbd;
    localparam logic [7:0] REG_CONN_LO = 8'hc0;
    localparam logic [7:0] REG_CONN_HI = 8'hc8;
    localparam logic [2:0] GRP_FLAGS   = 3'b001;
    localparam logic [2:0] GRP_AD      = 3'b011;
    localparam logic [2:0] GRP_SR      = 3'b100;

    typedef struct packed {
        logic [NUM_OPS-1:0] mask;
        logic [NUM_OPS-1:0] attack;
    } ph_wr_t;

    typedef struct packed {
        logic            hold_we;
        logic            ad_we;
        logic            sr_we;
        logic [OP_W-1:0] idx;
        logic [7:0]      val;
    } rate_wr_t;

    typedef struct packed {
        logic start;
        logic load;
        logic eval;
        logic mul;
        logic cmp;
        logic div_step;
        logic fix;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic ev_finish;
        logic ev_move;
        logic cmp_hit;
        logic div_done;
        logic rel;
        logic out_free;
        logic last_op;
    } status_t;

    // {valid, slot}
    function automatic logic [5:0] slot_of_offset(input logic [4:0] off);
        logic [5:0] r;
        case (off)
            5'd0:  r = {1'b1, 5'd0};
            5'd1:  r = {1'b1, 5'd2};
            5'd2:  r = {1'b1, 5'd4};
            5'd3:  r = {1'b1, 5'd1};
            5'd4:  r = {1'b1, 5'd3};
            5'd5:  r = {1'b1, 5'd5};
            5'd8:  r = {1'b1, 5'd6};
            5'd9:  r = {1'b1, 5'd8};
            5'd10: r = {1'b1, 5'd10};
            5'd11: r = {1'b1, 5'd7};
            5'd12: r = {1'b1, 5'd9};
            5'd13: r = {1'b1, 5'd11};
            5'd16: r = {1'b1, 5'd12};
            5'd17: r = {1'b1, 5'd14};
            5'd18: r = {1'b1, 5'd16};
            5'd19: r = {1'b1, 5'd13};
            5'd20: r = {1'b1, 5'd15};
            5'd21: r = {1'b1, 5'd17};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mod3(input logic [3:0] v);
        logic [1:0] r;
        case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            default:                              r = 2'd2;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fmet_snoop.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmet_snoop
// Register shadow, key-on/rhythm decode and channel mode store.
// ----------------------------------------------------------------------------
module fmet_snoop
    import fmet_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic            chip,
    input  logic [7:0]      addr,
    input  logic [7:0]      val,
    input  logic            is_opl3,
    input  logic [CH_W-1:0] mode_idx,
    output logic [2:0]      mode_out,
    output ph_wr_t          ph_wr,
    output rate_wr_t        rate_wr
);

    logic [7:0] bd0_reg;
    logic [7:0] bd1_reg;
    logic [5:0] r104_reg;
    logic       r105_reg;
    logic [8:0] kb0_reg;
    logic [8:0] kb1_reg;
    logic [8:0] cn0_reg;
    logic [8:0] cn1_reg;
    logic [2:0] mode_reg [NUM_CH];

    logic [NUM_CH-1:0] mode_we;
    logic [2:0]        mode_wv [NUM_CH];

    logic            is_key;
    logic [3:0]      c;
    logic [3:0]      c3;
    logic [CH_W-1:0] user;
    logic            inhib;
    logic            kb_old;
    logic            m1;
    logic            m2;
    logic [2:0]      pair;
    logic            four;
    logic            key_ev;
    logic [NUM_CH-1:0] key_ch;
    logic            bank;
    logic [7:0]      tog;
    logic [4:0]      rmask;
    logic [4:0]      on;
    logic [4:0]      off;
    logic [5:0]      on6;
    logic [5:0]      off6;
    logic [NUM_OPS-1:0] on36;
    logic [NUM_OPS-1:0] off36;
    logic [5:0]      slot;
    logic [4:0]      base_ch;

    assign is_key = (addr inside {[REG_KEY_LO:REG_KEY_HI]});
    assign c      = addr[3:0];
    assign c3     = 4'(c + 4'd3);
    assign user   = 5'({1'b0, c}) + (chip ? 5'd9 : 5'd0);
    assign kb_old = chip ? kb1_reg[c] : kb0_reg[c];
    assign m1     = chip ? cn1_reg[c] : cn0_reg[c];
    assign m2     = chip ? cn1_reg[c3] : cn0_reg[c3];
    assign pair   = (chip ? 3'd3 : 3'd0) + {1'b0, mod3(c)};
    assign four   = is_opl3 && r105_reg && (addr <= REG_KEY_4OP);
    assign bank   = !is_opl3 && chip;
    assign tog    = (bank ? bd1_reg : bd0_reg) ^ val;
    assign rmask  = val[5] ? 5'h1f : 5'h00;
    assign on     = tog[4:0] & val[4:0] & rmask;
    assign off    = tog[5] ? 5'h1f : (tog[4:0] & ~val[4:0] & rmask);
    assign on6    = {on[1], on[2], on[3], on[0], on[4], on[4]};
    assign off6   = {off[1], off[2], off[3], off[0], off[4], 1'b0};
    assign on36   = {30'd0, on6} << (bank ? 30 : 12);
    assign off36  = {30'd0, off6} << (bank ? 30 : 12);
    assign base_ch = bank ? 5'd15 : 5'd6;

    always_comb
    begin
        if (!is_opl3 && chip)
        begin
            inhib = bd1_reg[5] && (addr >= REG_KEY_PRC);
        end
        else if (!chip)
        begin
            inhib = bd0_reg[5] && (addr >= REG_KEY_PRC);
        end
        else
        begin
            inhib = 1'b0;
        end
    end

    assign key_ev = wr_en && is_key && !inhib && (kb_old ^ val[5]);

    always_comb
    begin
        key_ch  = '0;
        mode_we = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            mode_wv[i] = MODE_OFF;
        end
        if (key_ev)
        begin
            if (four && r104_reg[pair])
            begin
                if (addr <= REG_KEY_2OP)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (5'(i) == user || 5'(i) == 5'(user + 5'd3))
                        begin
                            key_ch[i] = 1'b1;
                        end
                        if (val[5] && 5'(i) == user)
                        begin
                            mode_we[i] = 1'b1;
                            mode_wv[i] = MODE_4OP_LOW + {2'b0, m1} + {1'b0, m2, 1'b0};
                        end
                        if (val[5] && 5'(i) == 5'(user + 5'd3))
                        begin
                            mode_we[i] = 1'b1;
                            mode_wv[i] = MODE_OFF;
                        end
                    end
                end
            end
            else
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (5'(i) == user)
                    begin
                        key_ch[i] = 1'b1;
                        mode_we[i] = val[5];
                        mode_wv[i] = m1 ? MODE_AM : MODE_FM;
                    end
                end
            end
        end
        if (wr_en && addr == REG_RHYTHM && tog[5])
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (5'(i) == base_ch || 5'(i) == 5'(base_ch + 5'd1) ||
                    5'(i) == 5'(base_ch + 5'd2))
                begin
                    mode_we[i] = 1'b1;
                    mode_wv[i] = val[5] ? MODE_PERC : MODE_OFF;
                end
            end
        end
    end

    always_comb
    begin
        ph_wr = '0;
        for (int i = 0; i < NUM_OPS; i++)
        begin
            if (key_ch[i/2])
            begin
                ph_wr.mask[i]   = 1'b1;
                ph_wr.attack[i] = val[5];
            end
            else if (wr_en && addr == REG_RHYTHM)
            begin
                if (on36[i])
                begin
                    ph_wr.mask[i]   = 1'b1;
                    ph_wr.attack[i] = 1'b1;
                end
                else if (off36[i])
                begin
                    ph_wr.mask[i] = 1'b1;
                end
            end
        end
    end

    assign slot = slot_of_offset(addr[4:0]);

    always_comb
    begin
        rate_wr     = '0;
        rate_wr.idx = 6'({1'b0, slot[4:0]}) + (chip ? 6'd18 : 6'd0);
        rate_wr.val = val;
        if (wr_en && slot[5])
        begin
            rate_wr.hold_we = (addr[7:5] == GRP_FLAGS);
            rate_wr.ad_we   = (addr[7:5] == GRP_AD);
            rate_wr.sr_we   = (addr[7:5] == GRP_SR);
        end
    end

    assign mode_out = mode_reg[mode_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bd0_reg  <= '0;
            bd1_reg  <= '0;
            r104_reg <= '0;
            r105_reg <= 1'b0;
            kb0_reg  <= '0;
            kb1_reg  <= '0;
            cn0_reg  <= '0;
            cn1_reg  <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                mode_reg[i] <= MODE_OFF;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (mode_we[i])
                begin
                    mode_reg[i] <= mode_wv[i];
                end
            end
            if (wr_en)
            begin
                if (addr == REG_RHYTHM)
                begin
                    if (chip)
                    begin
                        bd1_reg <= val;
                    end
                    if (!chip || is_opl3)
                    begin
                        bd0_reg <= val;
                    end
                end
                if (chip && addr == REG_4OP_EN)
                begin
                    r104_reg <= val[5:0];
                end
                if (chip && addr == REG_NEW)
                begin
                    r105_reg <= val[0];
                end
                if (is_key)
                begin
                    if (chip)
                    begin
                        kb1_reg[c] <= val[5];
                    end
                    else
                    begin
                        kb0_reg[c] <= val[5];
                    end
                end
                if (addr inside {[REG_CONN_LO:REG_CONN_HI]})
                begin
                    if (chip)
                    begin
                        cn1_reg[c] <= val[0];
                    end
                    else
                    begin
                        cn0_reg[c] <= val[0];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fmet_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmet_ctrl
// Sequencer for the per-operator envelope walk.
// ----------------------------------------------------------------------------
module fmet_ctrl
    import fmet_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    req_type,
    input  status_t st,
    output logic    in_stall,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIX  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && req_type)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.ev_finish)
                begin
                    state_next = S_EMIT;
                end
                else if (st.ev_move)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = st.cmp_hit ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = st.rel ? S_EMIT : S_EVAL;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = st.last_op ? S_IDLE : S_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fmet_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmet_datapath
// Operator store rings, envelope step unit, divider and output register.
// ----------------------------------------------------------------------------
module fmet_datapath
    import fmet_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            st,
    input  logic [COUNT_W-1:0] sample_count,
    input  ph_wr_t             ph_wr,
    input  rate_wr_t           rate_wr,
    output logic [CH_W-1:0]    mode_idx,
    input  logic [2:0]         mode_in,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [OP_W-1:0]    operator_index,
    output logic [2:0]         envelope_phase,
    output logic [LEVEL_W-1:0] envelope_level,
    output logic [2:0]         channel_mode,
    output logic               last_result
);

    localparam logic [STEP_W-1:0] STEP_TAB [16] = '{
        32'd0,
        32'(STEP_NUM / (SAMPLE_RATE * 1132) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 567) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 284) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 135) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 70) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 32) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 17) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 13) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 9) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 5) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 4) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 3) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 2) + 1),
        32'(STEP_NUM / (SAMPLE_RATE * 1) + 1),
        32'(FULL_SCALE)
    };
    localparam logic [OP_W-1:0] LAST_OP  = OP_W'(NUM_OPS - 1);
    localparam logic [4:0]      DIV_LAST = 5'(LEVEL_W - 1);

    logic [2:0]         ph_ring_reg   [NUM_OPS];
    logic [LEVEL_W-1:0] lvl_ring_reg  [NUM_OPS];
    logic [3:0]         atk_ring_reg  [NUM_OPS];
    logic [3:0]         dec_ring_reg  [NUM_OPS];
    logic [3:0]         rel_ring_reg  [NUM_OPS];
    logic [3:0]         sl_ring_reg   [NUM_OPS];
    logic               hold_ring_reg [NUM_OPS];

    logic [COUNT_W-1:0] n_reg;
    logic [OP_W-1:0]    op_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [2:0]         ph_reg;
    logic [COUNT_W-1:0] left_reg;
    logic [LEVEL_W-1:0] goal_reg;
    logic [STEP_W-1:0]  stp_reg;
    logic [2:0]         nxt_reg;
    logic               rel_reg;
    logic [STEP_W-1:0]  reach_reg;
    logic [LEVEL_W-1:0] dist_reg;
    logic [LEVEL_W:0]   rem_reg;
    logic [LEVEL_W-1:0] quo_reg;
    logic [4:0]         cnt_reg;

    logic               out_valid_reg;
    logic [OP_W-1:0]    out_op_reg;
    logic [2:0]         out_ph_reg;
    logic [LEVEL_W-1:0] out_lvl_reg;
    logic [2:0]         out_mode_reg;
    logic               out_last_reg;

    logic               ev_act;
    logic               ev_rel;
    logic [2:0]         ev_ph;
    logic [2:0]         ev_nxt;
    logic [LEVEL_W-1:0] ev_goal;
    logic [STEP_W-1:0]  ev_stp;
    logic               cmp_hit;
    logic [LEVEL_W:0]   rem_sh;
    logic               q_bit;

    always_comb
    begin
        ev_act  = 1'b0;
        ev_rel  = 1'b0;
        ev_ph   = ph_reg;
        ev_nxt  = PH_IDLE;
        ev_goal = '0;
        ev_stp  = '0;
        case (ph_reg)
            PH_ATTACK:
            begin
                ev_act  = 1'b1;
                ev_goal = FULL_SCALE;
                ev_stp  = STEP_TAB[atk_ring_reg[0]];
                ev_nxt  = PH_DECAY;
            end
            PH_DECAY:
            begin
                ev_act  = 1'b1;
                ev_goal = {2'b00, sl_ring_reg[0], 17'd0};
                ev_stp  = STEP_TAB[dec_ring_reg[0]];
                ev_nxt  = PH_SUSTAIN;
            end
            PH_SUSTAIN:
            begin
                ev_act = !hold_ring_reg[0];
                ev_rel = 1'b1;
                ev_ph  = PH_RELEASE;
                ev_stp = STEP_TAB[rel_ring_reg[0]];
            end
            PH_RELEASE:
            begin
                ev_act = 1'b1;
                ev_rel = 1'b1;
                ev_stp = STEP_TAB[rel_ring_reg[0]];
            end
            default:
            begin
                ev_act = 1'b0;
            end
        endcase
        if (left_reg == '0)
        begin
            ev_act = 1'b0;
        end
    end

    assign cmp_hit = (reach_reg >= {9'd0, dist_reg});
    assign rem_sh  = {rem_reg[LEVEL_W-1:0], quo_reg[LEVEL_W-1]};
    assign q_bit   = ({8'd0, rem_sh} >= stp_reg);

    assign st.ev_finish = !ev_act || (ev_stp == '0) || ((lvl_reg == ev_goal) && ev_rel);
    assign st.ev_move   = ev_act && (ev_stp != '0) && (lvl_reg != ev_goal);
    assign st.cmp_hit   = cmp_hit;
    assign st.div_done  = (cnt_reg == DIV_LAST);
    assign st.rel       = rel_reg;
    assign st.out_free  = !out_valid_reg || !out_stall;
    assign st.last_op   = (op_reg == LAST_OP);

    assign mode_idx = op_reg[OP_W-1:1];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg  <= sample_count;
        end
        if (cmd.load)
        begin
            lvl_reg  <= lvl_ring_reg[0];
            ph_reg   <= ph_ring_reg[0];
            left_reg <= n_reg;
        end
        if (cmd.eval && ev_act)
        begin
            if (ev_stp == '0)
            begin
                left_reg <= '0;
                ph_reg   <= ev_ph;
            end
            else if (lvl_reg == ev_goal)
            begin
                ph_reg <= ev_nxt;
            end
            else
            begin
                ph_reg   <= ev_ph;
                goal_reg <= ev_goal;
                stp_reg  <= ev_stp;
                nxt_reg  <= ev_nxt;
                rel_reg  <= ev_rel;
            end
        end
        if (cmd.mul)
        begin
            reach_reg <= (stp_reg >= STEP_W'(FULL_SCALE)) ? STEP_W'(FULL_SCALE)
                       : STEP_W'(STEP_W'(left_reg) * stp_reg);
            dist_reg  <= (lvl_reg < goal_reg) ? (goal_reg - lvl_reg) : (lvl_reg - goal_reg);
        end
        if (cmd.cmp)
        begin
            if (cmp_hit)
            begin
                lvl_reg <= goal_reg;
                ph_reg  <= nxt_reg;
                rem_reg <= '0;
                quo_reg <= dist_reg;
                cnt_reg <= '0;
            end
            else
            begin
                lvl_reg  <= (lvl_reg < goal_reg) ? (lvl_reg + reach_reg[LEVEL_W-1:0])
                          : (lvl_reg - reach_reg[LEVEL_W-1:0]);
                left_reg <= '0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? (rem_sh - stp_reg[LEVEL_W:0]) : rem_sh;
            quo_reg <= {quo_reg[LEVEL_W-2:0], q_bit};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.fix)
        begin
            left_reg <= ({7'd0, left_reg} < quo_reg) ? '0
                      : (left_reg - quo_reg[COUNT_W-1:0]);
        end
        if (cmd.emit)
        begin
            out_op_reg   <= op_reg;
            out_ph_reg   <= ph_reg;
            out_lvl_reg  <= lvl_reg;
            out_mode_reg <= mode_in;
            out_last_reg <= (op_reg == LAST_OP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                op_reg <= '0;
            end
            else if (cmd.emit)
            begin
                op_reg <= op_reg + 6'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OPS; i++)
            begin
                ph_ring_reg[i]   <= PH_IDLE;
                lvl_ring_reg[i]  <= '0;
                atk_ring_reg[i]  <= '0;
                dec_ring_reg[i]  <= '0;
                rel_ring_reg[i]  <= '0;
                sl_ring_reg[i]   <= '0;
                hold_ring_reg[i] <= 1'b0;
            end
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < NUM_OPS - 1; i++)
            begin
                ph_ring_reg[i]   <= ph_ring_reg[i+1];
                lvl_ring_reg[i]  <= lvl_ring_reg[i+1];
                atk_ring_reg[i]  <= atk_ring_reg[i+1];
                dec_ring_reg[i]  <= dec_ring_reg[i+1];
                rel_ring_reg[i]  <= rel_ring_reg[i+1];
                sl_ring_reg[i]   <= sl_ring_reg[i+1];
                hold_ring_reg[i] <= hold_ring_reg[i+1];
            end
            ph_ring_reg[NUM_OPS-1]   <= ph_reg;
            lvl_ring_reg[NUM_OPS-1]  <= lvl_reg;
            atk_ring_reg[NUM_OPS-1]  <= atk_ring_reg[0];
            dec_ring_reg[NUM_OPS-1]  <= dec_ring_reg[0];
            rel_ring_reg[NUM_OPS-1]  <= rel_ring_reg[0];
            sl_ring_reg[NUM_OPS-1]   <= sl_ring_reg[0];
            hold_ring_reg[NUM_OPS-1] <= hold_ring_reg[0];
        end
        else
        begin
            for (int i = 0; i < NUM_OPS; i++)
            begin
                if (ph_wr.mask[i])
                begin
                    ph_ring_reg[i] <= ph_wr.attack[i] ? PH_ATTACK : PH_RELEASE;
                end
                if (rate_wr.idx == OP_W'(i))
                begin
                    if (rate_wr.hold_we)
                    begin
                        hold_ring_reg[i] <= rate_wr.val[5];
                    end
                    if (rate_wr.ad_we)
                    begin
                        atk_ring_reg[i] <= rate_wr.val[7:4];
                        dec_ring_reg[i] <= rate_wr.val[3:0];
                    end
                    if (rate_wr.sr_we)
                    begin
                        sl_ring_reg[i]  <= rate_wr.val[7:4];
                        rel_ring_reg[i] <= rate_wr.val[3:0];
                    end
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign operator_index = out_op_reg;
    assign envelope_phase = out_ph_reg;
    assign envelope_level = out_lvl_reg;
    assign channel_mode   = out_mode_reg;
    assign last_result    = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result emitted while output register busy");
    a_rose_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("output valid without emit");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (stp_reg != '0))
        else $error("divide by zero step");
    a_no_wr_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (ph_wr.mask == '0))
        else $error("key event during ring rotation");

endmodule
`default_nettype wire

// ===== hw/rtl/fm_chip_envelope_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fm_chip_envelope_tracker_unit
// Snoops FM chip register writes and tracks ADSR envelopes of 36 operators.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_stall   req_type chip_select reg_address
//                                   reg_value sample_count
// out      out  out_valid/out_stall operator_index envelope_phase
//                                   envelope_level channel_mode last_result
// cfg      in   cfg_write_en        cfg_write_data (is_opl3)
//
// A register write is taken only while no advance runs. An advance gives 36
// results; each operator is loaded, evaluated and emitted, and each envelope
// segment it moves along passes evaluate, multiply and compare, then, if it
// reaches its target, a 23-step restoring divider and a fixup.
// Reset is asynchronous; all stores clear at once, no clearing pass.
// in_stall is high for the whole advance; out_stall holds the walk only at
// the point where a finished result waits for the output register.
// ----------------------------------------------------------------------------
module fm_chip_envelope_tracker_unit
    import fmet_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic               chip_select,
    input  logic [7:0]         reg_address,
    input  logic [7:0]         reg_value,
    input  logic [COUNT_W-1:0] sample_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [OP_W-1:0]    operator_index,
    output logic [2:0]         envelope_phase,
    output logic [LEVEL_W-1:0] envelope_level,
    output logic [2:0]         channel_mode,
    output logic               last_result
);

    logic            is_opl3_reg;
    logic            wr_en;
    cmd_t            cmd;
    status_t         st;
    ph_wr_t          ph_wr;
    rate_wr_t        rate_wr;
    logic [CH_W-1:0] mode_idx;
    logic [2:0]      mode_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_opl3_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            is_opl3_reg <= cfg_write_data;
        end
    end

    assign wr_en = in_valid && !in_stall && !req_type;

    fmet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .st       (st),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    fmet_snoop u_snoop (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .chip     (chip_select),
        .addr     (reg_address),
        .val      (reg_value),
        .is_opl3  (is_opl3_reg),
        .mode_idx (mode_idx),
        .mode_out (mode_val),
        .ph_wr    (ph_wr),
        .rate_wr  (rate_wr)
    );

    fmet_datapath #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .sample_count   (sample_count),
        .ph_wr          (ph_wr),
        .rate_wr        (rate_wr),
        .mode_idx       (mode_idx),
        .mode_in        (mode_val),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .operator_index (operator_index),
        .envelope_phase (envelope_phase),
        .envelope_level (envelope_level),
        .channel_mode   (channel_mode),
        .last_result    (last_result)
    );

endmodule
`default_nettype wire
